FILE: hw/rtl/fbh_pkg.sv
// Shared types, constants and helpers of the free-run buddy histogram.
package fbh_pkg;

  localparam int ByteW      = 8;
  localparam int OrderW     = 4;
  localparam int CountW     = 16;
  localparam int OrderSlots = 16;
  // One lane per bit position where a run can end, plus one for the run open at the byte end.
  localparam int Lanes      = ByteW + 1;
  localparam int AddW       = CountW + $clog2(Lanes);
  localparam int PopW       = $clog2(Lanes + 1);
  localparam int ZeroW      = $clog2(ByteW + 1);

  localparam logic [OrderW-1:0] OrderCapRst = OrderW'(10);
  localparam logic [CountW-1:0] CountMax    = '1;

  typedef logic [OrderW-1:0] order_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    count_t                  top_amt;
    logic [OrderSlots-1:0]   low_bits;
  } lane_out_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    order_t top;
  } stage_ctl_t;

  typedef struct packed {
    logic   valid;
    order_t top;
  } snap_ctl_t;

  function automatic order_t top_order(input order_t cap);
    if (int'(cap) > OrderSlots - 1) begin
      return order_t'(OrderSlots - 1);
    end
    return cap;
  endfunction

  function automatic count_t sat_count(input logic [AddW:0] value);
    if (value > {{(AddW + 1 - CountW){1'b0}}, CountMax}) begin
      return CountMax;
    end
    return value[CountW-1:0];
  endfunction

endpackage

FILE: hw/rtl/fbh_map_if.sv
// Input channel: one bitmap byte per transfer.
interface fbh_map_if
  import fbh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] map_byte;
  logic             last_byte;

  modport source (output valid, output map_byte, output last_byte, input ready);
  modport sink   (input valid, input map_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/fbh_res_if.sv
// Result channel: one order count per transfer.
interface fbh_res_if
  import fbh_pkg::*;
();
  logic   valid;
  logic   ready;
  order_t order;
  count_t chunk_count;
  logic   last_result;

  modport source (output valid, output order, output chunk_count, output last_result,
                  input ready);
  modport sink   (input valid, input order, input chunk_count, input last_result,
                  output ready);
endinterface

FILE: hw/rtl/fbh_lane.sv
// One lane: splits a finished run into per-order increments.
module fbh_lane
  import fbh_pkg::*;
(
  input  logic      clk_i,
  input  count_t    len_i,
  input  logic      act_i,
  input  order_t    top_i,
  output lane_out_t out_o
);

  lane_out_t out_d, out_q;

  always_comb begin
    out_d.top_amt  = act_i ? (len_i >> top_i) : '0;
    out_d.low_bits = '0;
    for (int k = 0; k < OrderSlots; k++) begin
      out_d.low_bits[k] = act_i && (OrderW'(k) < top_i) && len_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

FILE: hw/rtl/fbh_merge.sv
// Merging stage: sums the lane increments into the saturating order counters.
module fbh_merge
  import fbh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_out_t [Lanes-1:0]  lanes_i,
  input  stage_ctl_t             ctl_i,
  output count_t [OrderSlots-1:0] hist_o,
  output snap_ctl_t              snap_o
);

  count_t [OrderSlots-1:0] counts_q;
  count_t [OrderSlots-1:0] counts_d;
  logic   [AddW-1:0]       sum_top;

  always_comb begin
    logic [PopW-1:0] pop;
    logic [AddW-1:0] add;
    sum_top = '0;
    for (int l = 0; l < Lanes; l++) begin
      sum_top = sum_top + AddW'(lanes_i[l].top_amt);
    end
    for (int k = 0; k < OrderSlots; k++) begin
      pop = '0;
      for (int l = 0; l < Lanes; l++) begin
        pop = pop + PopW'(lanes_i[l].low_bits[k]);
      end
      add = (OrderW'(k) == ctl_i.top) ? sum_top : AddW'(pop);
      counts_d[k] = sat_count({1'b0, add} + (AddW + 1)'(counts_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
    end else if (ctl_i.valid) begin
      // The histogram is handed to the emitter and the counters start over.
      counts_q <= ctl_i.last ? '0 : counts_d;
    end
  end

  assign hist_o       = counts_d;
  assign snap_o.valid = ctl_i.valid && ctl_i.last;
  assign snap_o.top   = ctl_i.top;

endmodule

FILE: hw/rtl/fbh_emit.sv
// Snapshot of a finished histogram and the registered result stage.
module fbh_emit
  import fbh_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  count_t [OrderSlots-1:0] hist_i,
  input  snap_ctl_t               snap_i,
  output logic                    busy_o,
  fbh_res_if.source               res_o
);

  count_t [OrderSlots-1:0] snap_q;
  logic                    snap_valid_q;
  order_t                  snap_top_q;
  order_t                  idx_q;
  logic                    out_valid_q;
  order_t                  out_order_q;
  count_t                  out_count_q;
  logic                    out_last_q;
  logic                    load;

  assign load = snap_valid_q && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q       <= '0;
      snap_valid_q <= 1'b0;
      snap_top_q   <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_order_q  <= '0;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (snap_i.valid) begin
        snap_q       <= hist_i;
        snap_valid_q <= 1'b1;
        snap_top_q   <= snap_i.top;
        idx_q        <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == snap_top_q) begin
          snap_valid_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
        out_order_q <= idx_q;
        out_count_q <= snap_q[idx_q];
        out_last_q  <= (idx_q == snap_top_q);
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy_o            = snap_valid_q;
  assign res_o.valid       = out_valid_q;
  assign res_o.order       = out_order_q;
  assign res_o.chunk_count = out_count_q;
  assign res_o.last_result = out_last_q;

endmodule

FILE: hw/rtl/free_run_buddy_histogram_core.sv
// Top level of the free-run buddy histogram: run decode, lanes, merge and result stage.
// Throughput: one bitmap byte per cycle. A last byte waits while an earlier last byte is
// in the pipeline or its histogram still drains: top order + 1 result transfers.
// After the last byte's transfer, the first result passes the decode register, the lane register,
// the counter bank into the snapshot and the result register before it is valid.
// Reset clears the run length, the counters and the result stage; the order cap resets to 10.
module free_run_buddy_histogram_core
  import fbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fbh_map_if.sink     map_i,
  fbh_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  order_t      cfg_wdata_i
);

  order_t                   order_cap_q;
  count_t                   run_q, run_d;
  count_t [Lanes-1:0]       len_d, len_q;
  logic   [Lanes-1:0]       act_d, act_q;
  logic                     a_valid_q, a_last_q;
  order_t                   a_top_q;
  stage_ctl_t               b_ctl_q;
  lane_out_t [Lanes-1:0]    lane_out;
  count_t [OrderSlots-1:0]  hist;
  snap_ctl_t                snap;
  logic                     emit_busy;
  logic                     accept;

  // A last byte needs a free snapshot when it reaches the counters.
  assign map_i.ready = !map_i.last_byte ||
                       (!emit_busy && !(a_valid_q && a_last_q) &&
                        !(b_ctl_q.valid && b_ctl_q.last));
  assign accept = map_i.valid && map_i.ready;

  // Lane j sees the free run that ends just below bit j; the last lane sees the run
  // still open at the end of the byte, which is also the carried run length.
  always_comb begin
    logic [ZeroW-1:0] zeros;
    logic             reach;
    logic [CountW:0]  ext;
    logic [Lanes-1:0] end_v;
    end_v = {map_i.last_byte, map_i.map_byte};
    for (int j = 0; j < Lanes; j++) begin
      zeros = '0;
      reach = 1'b1;
      for (int i = ByteW - 1; i >= 0; i--) begin
        if (i < j) begin
          if (reach && !map_i.map_byte[i]) begin
            zeros = zeros + 1'b1;
          end else begin
            reach = 1'b0;
          end
        end
      end
      ext = {1'b0, run_q} + (CountW + 1)'(j);
      if (reach) begin
        len_d[j] = ext[CountW] ? CountMax : ext[CountW-1:0];
      end else begin
        len_d[j] = CountW'(zeros);
      end
      act_d[j] = end_v[j] && (len_d[j] != '0);
    end
    run_d = map_i.last_byte ? '0 : len_d[Lanes-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_cap_q <= OrderCapRst;
      run_q       <= '0;
      a_valid_q   <= 1'b0;
      a_last_q    <= 1'b0;
      a_top_q     <= '0;
      b_ctl_q     <= '0;
      len_q       <= '0;
      act_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        order_cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        run_q <= run_d;
        len_q <= len_d;
        act_q <= act_d;
      end
      a_valid_q     <= accept;
      a_last_q      <= accept && map_i.last_byte;
      a_top_q       <= top_order(order_cap_q);
      b_ctl_q.valid <= a_valid_q;
      b_ctl_q.last  <= a_last_q;
      b_ctl_q.top   <= a_top_q;
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    fbh_lane u_lane (
      .clk_i (clk_i),
      .len_i (len_q[g]),
      .act_i (act_q[g] && a_valid_q),
      .top_i (a_top_q),
      .out_o (lane_out[g])
    );
  end

  fbh_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .lanes_i (lane_out),
    .ctl_i   (b_ctl_q),
    .hist_o  (hist),
    .snap_o  (snap)
  );

  fbh_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hist_i (hist),
    .snap_i (snap),
    .busy_o (emit_busy),
    .res_o  (res_o)
  );

endmodule

FILE: hw/rtl/fbh_checker.sv
// Port-level checks of the free-run buddy histogram and their binding.
module fbh_checker
  import fbh_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   res_valid_i,
  input logic   res_ready_i,
  input order_t res_order_i,
  input count_t res_count_i,
  input logic   res_last_i,
  input logic   cfg_we_i,
  input order_t cfg_wdata_i
);

  order_t cfg_q;
  order_t exp_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= OrderCapRst;
      exp_order_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (res_valid_i && res_ready_i) begin
        exp_order_q <= res_last_i ? '0 : res_order_i + 1'b1;
      end
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_order_i) &&
    $stable(res_count_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  a_order_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_order_i == exp_order_q)
    else $error("result orders out of sequence");

  a_last_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_last_i |-> res_order_i == top_order(cfg_q))
    else $error("last result not at top order");

  a_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i |-> res_order_i < top_order(cfg_q))
    else $error("result order beyond top order");

endmodule

bind free_run_buddy_histogram_core fbh_checker u_fbh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_order_i (res_o.order),
  .res_count_i (res_o.chunk_count),
  .res_last_i  (res_o.last_result),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);

FILE: tb/tb_free_run_buddy_histogram_core.sv
// Testbench for the free-run buddy histogram core: a directed table, then random bitmaps.
module tb_free_run_buddy_histogram_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fbh_pkg::*;

  typedef struct packed {
    order_t     order;
    count_t     chunk_count;
    logic       last_result;
  } order_count_t;

  // One row of the directed plan. A typed row carries its histogram by hand: the count
  // at the top order, and a mask of the lower orders that hold a count of one.
  typedef struct packed {
    bit         set_cfg;
    order_t     cfg_val;
    logic [7:0] map_byte;
    logic       last;
    int         reps;
    bit         typed;
    count_t     top_cnt;
    logic [15:0] low_mask;
  } plan_row_t;

  localparam int PlanRows = 16;

  localparam plan_row_t Plan [PlanRows] = '{
    '{1'b0, 4'd0,  8'hFF, 1'b1, 1,    1'b1, 16'd0,     16'h0000},
    '{1'b0, 4'd0,  8'h00, 1'b1, 1,    1'b1, 16'd0,     16'h0008},
    '{1'b1, 4'd0,  8'h00, 1'b1, 1,    1'b1, 16'd8,     16'h0000},
    '{1'b0, 4'd0,  8'hFE, 1'b1, 1,    1'b1, 16'd1,     16'h0000},
    '{1'b1, 4'd15, 8'h00, 1'b1, 1,    1'b1, 16'd0,     16'h0008},
    '{1'b0, 4'd0,  8'h55, 1'b1, 1,    1'b0, 16'd0,     16'h0000},
    '{1'b0, 4'd0,  8'h00, 1'b0, 2,    1'b0, 16'd0,     16'h0000},
    '{1'b0, 4'd0,  8'hF0, 1'b1, 1,    1'b1, 16'd0,     16'h0014},
    '{1'b1, 4'd4,  8'hAA, 1'b0, 1,    1'b0, 16'd0,     16'h0000},
    '{1'b0, 4'd0,  8'h81, 1'b0, 1,    1'b0, 16'd0,     16'h0000},
    '{1'b0, 4'd0,  8'h7E, 1'b1, 1,    1'b0, 16'd0,     16'h0000},
    '{1'b1, 4'd6,  8'h00, 1'b0, 16,   1'b0, 16'd0,     16'h0000},
    '{1'b0, 4'd0,  8'h01, 1'b0, 1,    1'b0, 16'd0,     16'h0000},
    '{1'b1, 4'd2,  8'h00, 1'b1, 1,    1'b0, 16'd0,     16'h0000},
    '{1'b1, 4'd10, 8'hFF, 1'b1, 1,    1'b1, 16'd0,     16'h0000},
    '{1'b1, 4'd15, 8'h00, 1'b1, 4,    1'b1, 16'd0,     16'h0020}
  };

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   cfg_we_i;
  order_t cfg_wdata_i;
  bit     calm = 1'b0;
  int     errors = 0;

  fbh_map_if map_if ();
  fbh_res_if res_if ();

  free_run_buddy_histogram_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_i       (map_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: register copy, open run and per-order tallies.
  order_t       order_cap_q;
  logic         run_open;
  logic [15:0]  run_len;
  count_t       order_tally [OrderSlots];
  order_count_t pending_counts [$];

  function automatic order_t top_of(input order_t mo);
    return (int'(mo) > OrderSlots - 1) ? order_t'(OrderSlots - 1) : mo;
  endfunction

  function automatic void credit_order(input int slot, input count_t amount);
    logic [CountW:0] sum;
    sum = {1'b0, order_tally[slot]} + {1'b0, amount};
    order_tally[slot] = sum[CountW] ? CountMax : sum[CountW-1:0];
  endfunction

  // A finished run is split with the register value in force when it ends.
  function automatic void close_run(input logic [15:0] len);
    order_t top;
    top = top_of(order_cap_q);
    credit_order(int'(top), count_t'(len >> top));
    for (int k = 0; k < int'(top); k++) begin
      credit_order(k, count_t'((len >> k) & 16'd1));
    end
  endfunction

  function automatic void clear_histogram();
    run_open = 1'b0;
    run_len  = '0;
    foreach (order_tally[k]) order_tally[k] = '0;
  endfunction

  task automatic fold_map_byte(input logic [7:0] bits, input logic last,
                               output order_count_t outs [$]);
    order_t top;
    outs = {};
    for (int j = 0; j < ByteW; j++) begin
      if (!bits[j]) begin
        run_open = 1'b1;
        if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
      end else if (run_open) begin
        close_run(run_len);
        run_open = 1'b0;
        run_len  = '0;
      end
    end
    if (last) begin
      if (run_open) close_run(run_len);
      top = top_of(order_cap_q);
      for (int j = 0; j <= int'(top); j++) begin
        outs.push_back('{order: order_t'(j), chunk_count: order_tally[j],
                         last_result: logic'(j == int'(top))});
      end
      clear_histogram();
    end
  endtask

  function automatic order_t pick_order_cap();
    case ($urandom_range(3))
      0:       return order_t'(0);
      1:       return order_t'(15);
      default: return order_t'($urandom_range(15));
    endcase
  endfunction

  task automatic send_map_byte(input logic [7:0] bits, input logic last,
                               output order_count_t outs [$]);
    if (!calm && $urandom_range(99) < 3) begin
      map_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    map_if.valid     <= 1'b1;
    map_if.map_byte  <= bits;
    map_if.last_byte <= last;
    @(posedge clk_i);
    while (!map_if.ready) @(posedge clk_i);
    fold_map_byte(bits, last, outs);
  endtask

  // Let the block settle: no byte offered, all counts back, pipeline empty.
  task automatic wait_drained();
    map_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_order_cap(input order_t value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_cap_q = value;
  endtask

  always @(posedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    order_count_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result: order %0d chunk_count %0d last_result %0b",
                 $time, res_if.order, res_if.chunk_count, res_if.last_result);
        errors++;
      end else begin
        want = pending_counts.pop_front();
        if (res_if.order !== want.order) begin
          $display("%0t: order: expected %0d, got %0d", $time, want.order, res_if.order);
          errors++;
        end
        if (res_if.chunk_count !== want.chunk_count) begin
          $display("%0t: chunk_count of order %0d: expected %0d, got %0d",
                   $time, want.order, want.chunk_count, res_if.chunk_count);
          errors++;
        end
        if (res_if.last_result !== want.last_result) begin
          $display("%0t: last_result of order %0d: expected %0b, got %0b",
                   $time, want.order, want.last_result, res_if.last_result);
          errors++;
        end
      end
    end
  end

  initial begin
    order_count_t outs [$];
    order_t       top;
    logic [7:0]   bits;
    logic         last;
    int           sent;
    int           maps;
    int           len;
    map_if.valid     <= 1'b0;
    map_if.map_byte  <= '0;
    map_if.last_byte <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    rst_ni           <= 1'b0;
    order_cap_q = OrderCapRst;
    clear_histogram();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Plan[i]) begin
      if (Plan[i].set_cfg) write_order_cap(Plan[i].cfg_val);
      for (int r = 0; r < Plan[i].reps; r++) begin
        last = Plan[i].last && (r == Plan[i].reps - 1);
        send_map_byte(Plan[i].map_byte, last, outs);
        if (Plan[i].typed && outs.size() != 0) begin
          top  = top_of(order_cap_q);
          outs = {};
          for (int j = 0; j <= int'(top); j++) begin
            outs.push_back('{order: order_t'(j),
                             chunk_count: (j == int'(top)) ? Plan[i].top_cnt
                                                           : count_t'(Plan[i].low_mask[j]),
                             last_result: logic'(j == int'(top))});
          end
        end
        foreach (outs[k]) pending_counts.push_back(outs[k]);
      end
    end

    // Random bitmaps: mostly short ones, some long enough to reach the higher orders.
    sent = 0;
    maps = 0;
    while (sent < 100) begin
      calm = (maps >= 8 && maps < 14);
      if ($urandom_range(99) < 30) write_order_cap(pick_order_cap());
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
      for (int b = 0; b < len; b++) begin
        if (b != 0 && b == len / 2 && $urandom_range(9) == 0) begin
          write_order_cap(pick_order_cap());
        end
        case ($urandom_range(9))
          0, 1, 2: bits = 8'h00;
          3, 4:    bits = 8'hFF;
          default: bits = 8'($urandom);
        endcase
        send_map_byte(bits, logic'(b == len - 1), outs);
        foreach (outs[k]) pending_counts.push_back(outs[k]);
        sent++;
      end
      maps++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
